/* rtl/core/srlm_pkg.sv */
// Package for the session rate limit monitor.
// Holds the transaction structs, opcode and status codes and sizing constants.
// No dependencies.
package srlm_pkg;

   localparam int NumMetrics = 5;
   localparam int IdleMetric = 4;
   localparam int LimitRegs  = 5;

   localparam int MetricIdxW = (NumMetrics > 1) ? $clog2(NumMetrics) : 1;
   localparam int LimitIdxW  = $clog2(LimitRegs);
   localparam int CsrIdxW    = 3;
   localparam int CsrDataW   = 32;
   localparam int TimeW      = 48;
   localparam int CountW     = 33;
   localparam int AmountW    = 16;

   localparam logic [CsrDataW-1:0] WindowReset     = 32'd60000;
   localparam logic [CsrDataW-1:0] UnverifiedReset = 32'd5000;

   localparam logic [CsrIdxW-1:0] CSR_WINDOW     = 3'd5;
   localparam logic [CsrIdxW-1:0] CSR_UNVERIFIED = 3'd6;

   typedef enum logic [2:0] {
      OP_ACTIVATE  = 3'd0,
      OP_ACTIVITY  = 3'd1,
      OP_INCREMENT = 3'd2,
      OP_IDLE_CHK  = 3'd3,
      OP_VERIFY    = 3'd4,
      OP_REQ_CLOSE = 3'd5,
      OP_CLOSE     = 3'd6
   } opcode_type;

   typedef enum logic [1:0] {
      ST_NONE       = 2'd0,
      ST_ACTIVE     = 2'd1,
      ST_MUST_CLOSE = 2'd2,
      ST_CLOSED     = 2'd3
   } status_type;

   typedef struct packed {
      logic [2:0]         opcode;
      logic [2:0]         metric_index;
      logic [AmountW-1:0] amount;
      logic [TimeW-1:0]   time_now_ms;
   } req_type;

   typedef struct packed {
      logic [1:0] session_status;
      logic       violation;
      logic [2:0] violated_metric;
      logic       idle_expired;
      logic       is_verified;
   } rsp_type;

   typedef struct packed {
      logic [LimitRegs-1:0][CsrDataW-1:0] limit;
      logic [CsrDataW-1:0]                window_ms;
      logic [CsrDataW-1:0]                unverified_timeout_ms;
   } cfg_type;

   typedef struct packed {
      logic       violation;
      logic [2:0] metric;
   } viol_type;

endpackage

/* rtl/core/srlm_metric_bank.sv */
// Fixed-window counters, one per metric, updated by increment transactions.
// Depends on srlm_pkg.
module srlm_metric_bank (
   input  logic             clock,
   input  logic             reset,
   input  logic             fire,
   input  srlm_pkg::req_type req,
   input  srlm_pkg::cfg_type cfg,
   output srlm_pkg::viol_type viol
);
   import srlm_pkg::*;

   logic [NumMetrics-1:0][CountW-1:0] count_ff;
   logic [NumMetrics-1:0][TimeW-1:0]  start_ff;
   logic [CountW-1:0]   count_in;
   logic [TimeW-1:0]    start_in;
   logic [MetricIdxW-1:0] sel;
   logic                in_range;
   logic [CsrDataW-1:0] lim;
   logic                enabled;
   logic [CountW:0]     sum;
   logic [CountW-1:0]   cnt_sat;
   logic [TimeW-1:0]    start_cur;
   logic [TimeW-1:0]    start_eff;
   logic [TimeW-1:0]    elapsed;
   logic                in_window;
   logic                over;
   logic                hit;

   always_comb begin
      sel      = req.metric_index[MetricIdxW-1:0];
      in_range = {1'b0, req.metric_index} < 4'(NumMetrics);
      if ({1'b0, req.metric_index} < 4'(LimitRegs)) begin
         lim = cfg.limit[req.metric_index[LimitIdxW-1:0]];
      end else begin
         lim = '0;
      end
      enabled   = (req.opcode == OP_INCREMENT) && in_range && (lim != '0);
      sum       = {1'b0, count_ff[sel]} + (CountW+1)'(req.amount);
      cnt_sat   = sum[CountW] ? '1 : sum[CountW-1:0];
      start_cur = start_ff[sel];
      start_eff = (start_cur == '0) ? req.time_now_ms : start_cur;
      elapsed   = req.time_now_ms - start_eff;
      in_window = elapsed <= TimeW'(cfg.window_ms);
      over      = cnt_sat > CountW'(lim);
      hit       = enabled && in_window && over;
      if (in_window && over) begin
         count_in = '0;
         start_in = '0;
      end else if (!in_window) begin
         count_in = CountW'(req.amount);
         start_in = req.time_now_ms;
      end else begin
         count_in = cnt_sat;
         start_in = start_eff;
      end
      viol.violation = hit;
      viol.metric    = hit ? req.metric_index : 3'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         start_ff <= '0;
      end else if (fire && enabled) begin
         for (int k = 0; k < NumMetrics; k++) begin
            if (sel == MetricIdxW'(k)) begin
               count_ff[k] <= count_in;
               start_ff[k] <= start_in;
            end
         end
      end
   end

endmodule

/* rtl/core/srlm_session_ctrl.sv */
// Session status, verified flag, last activity time and the idle check.
// Builds the result transaction. Depends on srlm_pkg.
module srlm_session_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              fire,
   input  srlm_pkg::req_type  req,
   input  srlm_pkg::cfg_type  cfg,
   input  srlm_pkg::viol_type viol,
   output srlm_pkg::rsp_type  rsp
);
   import srlm_pkg::*;

   status_type          status_ff;
   status_type          status_in;
   logic                verified_ff;
   logic                verified_in;
   logic [TimeW-1:0]    last_ff;
   logic [TimeW-1:0]    last_in;
   logic [CsrDataW-1:0] idle_lim;
   logic [CsrDataW-1:0] timeout;
   logic [TimeW-1:0]    idle_time;
   logic                expired;
   status_type          closure;

   always_comb begin
      if (IdleMetric < NumMetrics && IdleMetric < LimitRegs) begin
         idle_lim = cfg.limit[LimitIdxW'(IdleMetric % LimitRegs)];
      end else begin
         idle_lim = '0;
      end
      timeout   = verified_ff ? idle_lim : cfg.unverified_timeout_ms;
      idle_time = req.time_now_ms - last_ff;
      expired   = (req.opcode == OP_IDLE_CHK) && (timeout != '0) &&
                  (idle_time >= TimeW'(timeout));
      closure   = (status_ff == ST_CLOSED) ? ST_CLOSED : ST_MUST_CLOSE;
   end

   always_comb begin
      status_in   = status_ff;
      verified_in = verified_ff;
      last_in     = last_ff;
      case (req.opcode)
         OP_ACTIVATE: begin
            if (status_ff == ST_NONE) begin
               status_in = ST_ACTIVE;
               last_in   = req.time_now_ms;
            end
         end
         OP_ACTIVITY: begin
            if (status_ff != ST_CLOSED) begin
               last_in = req.time_now_ms;
            end
         end
         OP_INCREMENT: begin
            if (viol.violation) begin
               status_in = closure;
            end
         end
         OP_IDLE_CHK: begin
            if (expired) begin
               status_in = closure;
            end
         end
         OP_VERIFY:    verified_in = 1'b1;
         OP_REQ_CLOSE: status_in = closure;
         OP_CLOSE:     status_in = ST_CLOSED;
         default:      status_in = status_ff;
      endcase
   end

   always_comb begin
      rsp.session_status  = status_in;
      rsp.violation       = viol.violation;
      rsp.violated_metric = viol.metric;
      rsp.idle_expired    = expired;
      rsp.is_verified     = verified_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff   <= ST_NONE;
         verified_ff <= 1'b0;
         last_ff     <= '0;
      end else if (fire) begin
         status_ff   <= status_in;
         verified_ff <= verified_in;
         last_ff     <= last_in;
      end
   end

endmodule

/* rtl/core/session_rate_limit_monitor.sv */
// Top level of the session rate limit monitor: configuration registers,
// input and result registers. Depends on srlm_pkg, srlm_metric_bank and
// srlm_session_ctrl.
//
//   Channel  Ports                          Direction  Content
//   req      req_valid/req_ready/req_data   in         one event transaction
//   rsp      rsp_valid/rsp_ready/rsp_data   out        one result transaction
//   csr      csr_wr_en/csr_index/csr_wdata  in         register write
//
// A transaction is captured in the input register, evaluated against the
// session state when the result register can take it, and stored there.
// One transaction per cycle is sustained while rsp_ready stays high; the
// result is offered once it is stored in the result register.
// A stalled result holds the result register and any transaction waiting in
// the input register; the input register still frees up in the cycle the
// result is taken. Reset restores all but the input and result data regs.
module session_rate_limit_monitor (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  srlm_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output srlm_pkg::rsp_type                   rsp_data,
   input  logic                                csr_wr_en,
   input  logic [srlm_pkg::CsrIdxW-1:0]        csr_index,
   input  logic [srlm_pkg::CsrDataW-1:0]       csr_wdata
);
   import srlm_pkg::*;

   cfg_type  cfg_ff;
   req_type  req_ff;
   logic     req_valid_ff;
   rsp_type  rsp_ff;
   logic     rsp_valid_ff;
   rsp_type  rsp_in;
   viol_type viol;
   logic     advance;
   logic     fire;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign fire      = req_valid_ff && advance;
   assign req_ready = !req_valid_ff || advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.limit                 <= '0;
         cfg_ff.window_ms             <= WindowReset;
         cfg_ff.unverified_timeout_ms <= UnverifiedReset;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_WINDOW:     cfg_ff.window_ms <= csr_wdata;
            CSR_UNVERIFIED: cfg_ff.unverified_timeout_ms <= csr_wdata;
            default: begin
               if ({1'b0, csr_index} < (CsrIdxW+1)'(LimitRegs)) begin
                  cfg_ff.limit[csr_index[LimitIdxW-1:0]] <= csr_wdata;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            req_valid_ff <= req_valid;
         end
         if (fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff <= req_data;
      end
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

   srlm_metric_bank u_metric_bank (
      .clock (clock),
      .reset (reset),
      .fire  (fire),
      .req   (req_ff),
      .cfg   (cfg_ff),
      .viol  (viol)
   );

   srlm_session_ctrl u_session_ctrl (
      .clock (clock),
      .reset (reset),
      .fire  (fire),
      .req   (req_ff),
      .cfg   (cfg_ff),
      .viol  (viol),
      .rsp   (rsp_in)
   );

endmodule

/* dv/tb_session_rate_limit_monitor.sv */
// Self-checking testbench for session_rate_limit_monitor: directed and random
// events, with a transaction-level predictor of the session policer.
// Depends on srlm_pkg and the session_rate_limit_monitor RTL.
module tb_session_rate_limit_monitor;
   timeunit 1ns;
   timeprecision 1ps;

   import srlm_pkg::*;

   localparam int CycleLimit = 400000;
   localparam int PhaseItems = 325;
   localparam logic [2:0] OpReserved = 3'd7;
   localparam logic [CsrIdxW-1:0] CsrLimit0 = 3'd0;
   localparam logic [CsrIdxW-1:0] CsrSpare = 3'd7;
   localparam logic [CountW-1:0] CountMax = '1;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic csr_wr_en = 1'b0;
   logic [CsrIdxW-1:0] csr_index = '0;
   logic [CsrDataW-1:0] csr_wdata = '0;

   session_rate_limit_monitor u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Predictor copy of the configuration and of the session state.
   logic [CsrDataW-1:0] limit_cfg [LimitRegs] = '{default: '0};
   logic [CsrDataW-1:0] window_cfg = WindowReset;
   logic [CsrDataW-1:0] unverified_cfg = UnverifiedReset;
   status_type sess_state = ST_NONE;
   logic verified = 1'b0;
   logic [TimeW-1:0] last_seen_ms = '0;
   logic [CountW-1:0] metric_total [NumMetrics] = '{default: '0};
   logic [TimeW-1:0] window_open_ms [NumMetrics] = '{default: '0};

   req_type queued_events [$];
   rsp_type predicted_verdicts [$];
   rsp_type want;
   bit req_took = 1'b0;
   int error_count = 0;
   int cycle_count = 0;
   int burst_left = 0;
   int gap_left = 0;
   int stall_left = 0;
   int ready_mode = 0;
   int unsigned amount_cap = 15;
   logic [TimeW-1:0] clock_ms = '0;

   function automatic void request_close_if_open();
      if (sess_state != ST_CLOSED) sess_state = ST_MUST_CLOSE;
   endfunction

   function automatic rsp_type police_event(input req_type ev);
      rsp_type verdict;
      logic [CountW:0] sum;
      logic [CountW-1:0] total;
      logic [TimeW-1:0] elapsed;
      logic [CsrDataW-1:0] timeout;
      int m;
      verdict = '0;
      m = ev.metric_index;
      case (ev.opcode)
         OP_ACTIVATE: begin
            if (sess_state == ST_NONE) begin
               sess_state = ST_ACTIVE;
               last_seen_ms = ev.time_now_ms;
            end
         end
         OP_ACTIVITY: begin
            if (sess_state != ST_CLOSED) last_seen_ms = ev.time_now_ms;
         end
         OP_INCREMENT: begin
            if (m < NumMetrics && m < LimitRegs && limit_cfg[m] != '0) begin
               sum = metric_total[m] + ev.amount;
               total = (sum > CountMax) ? CountMax : sum[CountW-1:0];
               if (window_open_ms[m] == '0) window_open_ms[m] = ev.time_now_ms;
               elapsed = ev.time_now_ms - window_open_ms[m];
               if (elapsed <= window_cfg && total > limit_cfg[m]) begin
                  request_close_if_open();
                  window_open_ms[m] = '0;
                  total = '0;
                  verdict.violation = 1'b1;
                  verdict.violated_metric = 3'(m);
               end else if (elapsed > window_cfg) begin
                  window_open_ms[m] = ev.time_now_ms;
                  total = CountW'(ev.amount);
               end
               metric_total[m] = total;
            end
         end
         OP_IDLE_CHK: begin
            if (verified) begin
               timeout = (IdleMetric < NumMetrics && IdleMetric < LimitRegs) ?
                         limit_cfg[IdleMetric] : '0;
            end else begin
               timeout = unverified_cfg;
            end
            elapsed = ev.time_now_ms - last_seen_ms;
            if (timeout != '0 && elapsed >= timeout) begin
               request_close_if_open();
               verdict.idle_expired = 1'b1;
            end
         end
         OP_VERIFY: verified = 1'b1;
         OP_REQ_CLOSE: request_close_if_open();
         OP_CLOSE: sess_state = ST_CLOSED;
         default: ;
      endcase
      verdict.session_status = sess_state;
      verdict.is_verified = verified;
      return verdict;
   endfunction

   task automatic check_field(input string name, input int unsigned exp_val,
                              input int unsigned got_val);
      if (exp_val != got_val) begin
         $error("%s mismatch: expected %0d, actual %0d", name, exp_val, got_val);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("session_rate_limit_monitor verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      req_took = 1'b0;
      if (!reset) begin
         if (req_valid && req_ready) begin
            predicted_verdicts = {predicted_verdicts, police_event(req_data)};
            req_took = 1'b1;
         end
         if (rsp_valid && rsp_ready) begin
            if (predicted_verdicts.size() == 0) begin
               $error("result transaction with nothing predicted: %p", rsp_data);
               error_count++;
            end else begin
               want = predicted_verdicts.pop_front();
               check_field("session_status", want.session_status, rsp_data.session_status);
               check_field("violation", want.violation, rsp_data.violation);
               check_field("violated_metric", want.violated_metric,
                           rsp_data.violated_metric);
               check_field("idle_expired", want.idle_expired, rsp_data.idle_expired);
               check_field("is_verified", want.is_verified, rsp_data.is_verified);
            end
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_took) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (queued_events.size() > 0) begin
            req_data <= queued_events.pop_front();
            req_valid <= 1'b1;
            if (burst_left > 1) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 24);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (cycle_count % 256 == 0) ready_mode = $urandom_range(0, 2);
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (ready_mode == 0) begin
         rsp_ready <= 1'b1;
      end else if (ready_mode == 1) begin
         rsp_ready <= ($urandom_range(0, 3) != 0);
      end else if ($urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(0, 14);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic queue_event(input logic [2:0] op, input logic [2:0] idx,
                              input logic [AmountW-1:0] amt, input logic [TimeW-1:0] at_ms);
      req_type ev;
      ev.opcode = op;
      ev.metric_index = idx;
      ev.amount = amt;
      ev.time_now_ms = at_ms;
      queued_events = {queued_events, ev};
   endtask

   task automatic drain();
      while (queued_events.size() != 0 || req_valid || predicted_verdicts.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_reg(input logic [CsrIdxW-1:0] idx, input logic [CsrDataW-1:0] val);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      if (idx < LimitRegs) limit_cfg[idx] = val;
      else if (idx == CSR_WINDOW) window_cfg = val;
      else if (idx == CSR_UNVERIFIED) unverified_cfg = val;
   endtask

   task automatic load_config(input cfg_type c);
      for (int k = 0; k < LimitRegs; k++) set_reg(CsrLimit0 + 3'(k), c.limit[k]);
      set_reg(CSR_WINDOW, c.window_ms);
      set_reg(CSR_UNVERIFIED, c.unverified_timeout_ms);
      set_reg(CsrSpare, $urandom);
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   function automatic cfg_type random_config();
      cfg_type c;
      for (int k = 0; k < LimitRegs; k++) c.limit[k] = 32'($urandom_range(1, 400));
      c.limit[$urandom_range(0, LimitRegs - 1)] = '0;
      c.window_ms = 32'($urandom_range(1, 5000));
      c.unverified_timeout_ms = 32'($urandom_range(0, 8000));
      return c;
   endfunction

   task automatic queue_random(input int count, input bit may_verify, input bit may_close);
      req_type ev;
      int unsigned pick;
      int unsigned span;
      for (int n = 0; n < count; n++) begin
         span = (window_cfg == '0) ? 8 : ((window_cfg > 32'd20000) ? 20000 : window_cfg);
         pick = $urandom_range(0, 99);
         if (pick < 48) ev.opcode = OP_INCREMENT;
         else if (pick < 63) ev.opcode = OP_ACTIVITY;
         else if (pick < 78) ev.opcode = OP_IDLE_CHK;
         else if (pick < 82) ev.opcode = OP_ACTIVATE;
         else if (pick < 85) ev.opcode = OpReserved;
         else if (pick < 88 && may_verify) ev.opcode = OP_VERIFY;
         else if (pick < 91 && may_close) ev.opcode = OP_REQ_CLOSE;
         else if (pick < 93 && may_close) ev.opcode = OP_CLOSE;
         else ev.opcode = OP_INCREMENT;
         ev.metric_index = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7)) :
                           3'($urandom_range(0, NumMetrics - 1));
         ev.amount = ($urandom_range(0, 15) == 0) ? AmountW'($urandom) :
                     AmountW'($urandom_range(0, amount_cap));
         case ($urandom_range(0, 19))
            0: clock_ms = {16'($urandom), $urandom};
            1: clock_ms = clock_ms + span + 1 + $urandom_range(0, span);
            default: clock_ms = clock_ms + $urandom_range(0, span / 4 + 1);
         endcase
         ev.time_now_ms = clock_ms;
         queued_events = {queued_events, ev};
      end
   endtask

   task automatic run_phase(input cfg_type c, input int unsigned cap,
                            input bit may_verify, input bit may_close);
      drain();
      load_config(c);
      amount_cap = cap;
      queue_random(PhaseItems, may_verify, may_close);
   endtask

   initial begin
      cfg_type c;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset configuration: every metric is off and the session starts unverified.
      @(posedge clock);
      queue_event(OpReserved, 3'd7, 16'hFFFF, 48'hFFFF_FFFF_FFFF);
      queue_event(OP_ACTIVITY, 3'd0, 16'd0, 48'd100);
      queue_event(OP_IDLE_CHK, 3'd0, 16'd0, 48'd5099);
      queue_event(OP_INCREMENT, 3'd0, 16'd10, 48'd5100);
      queue_event(OP_ACTIVATE, 3'd0, 16'd0, 48'd200);
      queue_event(OP_ACTIVATE, 3'd0, 16'd0, 48'd300);
      queue_event(OP_IDLE_CHK, 3'd0, 16'd0, 48'd5199);
      drain();

      c.limit[0] = 32'd10;
      c.limit[1] = 32'hFFFF_FFFF;
      c.limit[2] = 32'd1;
      c.limit[3] = 32'd100;
      c.limit[4] = 32'd3000;
      c.window_ms = 32'd1000;
      c.unverified_timeout_ms = '0;
      load_config(c);
      queue_event(OP_IDLE_CHK, 3'd0, 16'd0, 48'hFFFF_FFFF_FFFF);
      queue_event(OP_INCREMENT, 3'd0, 16'd4, 48'd0);
      queue_event(OP_INCREMENT, 3'd0, 16'd6, 48'd1000);
      queue_event(OP_INCREMENT, 3'd0, 16'd0, 48'd2000);
      queue_event(OP_INCREMENT, 3'd0, 16'd5, 48'd2001);
      queue_event(OP_INCREMENT, 3'd5, 16'hFFFF, 48'd2002);
      queue_event(OP_INCREMENT, 3'd7, 16'hFFFF, 48'd2002);
      queue_event(OP_INCREMENT, 3'd1, 16'hFFFF, 48'd2003);
      queue_event(OP_REQ_CLOSE, 3'd0, 16'd0, 48'd2004);
      queue_event(OP_INCREMENT, 3'd3, 16'd60, 48'hFFFF_FFFF_FF9C);
      queue_event(OP_INCREMENT, 3'd3, 16'd60, 48'd50);
      queue_event(OP_VERIFY, 3'd0, 16'd0, 48'd60);
      queue_event(OP_ACTIVITY, 3'd0, 16'd0, 48'd1000);
      queue_event(OP_IDLE_CHK, 3'd0, 16'd0, 48'd3999);
      queue_event(OP_IDLE_CHK, 3'd0, 16'd0, 48'd4000);
      queue_event(OP_INCREMENT, 3'd2, 16'd2, 48'd4001);
      clock_ms = 48'd10000;

      c.limit[0] = 32'd20;
      c.limit[1] = 32'd50;
      c.limit[2] = 32'd5;
      c.limit[3] = 32'd200;
      c.limit[4] = 32'd4000;
      c.window_ms = 32'd1000;
      c.unverified_timeout_ms = 32'd3000;
      run_phase(c, 15, 1'b0, 1'b0);

      c.limit = '{default: 32'd1};
      c.window_ms = '0;
      c.unverified_timeout_ms = 32'd1;
      run_phase(c, 3, 1'b1, 1'b0);

      c.limit = '{default: 32'hFFFF_FFFF};
      c.window_ms = 32'hFFFF_FFFF;
      c.unverified_timeout_ms = 32'hFFFF_FFFF;
      run_phase(c, 65535, 1'b1, 1'b0);

      run_phase(random_config(), 100, 1'b1, 1'b0);

      c.limit[0] = '0;
      c.limit[1] = 32'd10;
      c.limit[2] = 32'hFFFF_FFFF;
      c.limit[3] = 32'd100;
      c.limit[4] = 32'd500;
      c.window_ms = 32'd60000;
      c.unverified_timeout_ms = '0;
      run_phase(c, 40, 1'b1, 1'b0);

      drain();
      clock_ms = clock_ms + 48'd10;
      queue_event(OP_CLOSE, 3'd0, 16'd0, clock_ms);
      queue_event(OP_REQ_CLOSE, 3'd0, 16'd0, clock_ms);
      queue_event(OP_ACTIVITY, 3'd0, 16'd0, clock_ms);
      queue_event(OP_INCREMENT, 3'd1, 16'hFFFF, clock_ms);
      queue_event(OP_INCREMENT, 3'd1, 16'hFFFF, clock_ms);
      queue_event(OP_IDLE_CHK, 3'd0, 16'd0, clock_ms + 48'd100000);
      clock_ms = clock_ms + 48'd100000;

      run_phase(random_config(), 100, 1'b1, 1'b1);

      drain();
      if (error_count == 0) begin
         $display("session_rate_limit_monitor verification clean");
      end else begin
         $display("session_rate_limit_monitor verification failed");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/core/srlm_pkg.sv
rtl/core/srlm_metric_bank.sv
rtl/core/srlm_session_ctrl.sv
rtl/core/session_rate_limit_monitor.sv
dv/tb_session_rate_limit_monitor.sv
